// File: design/sha224_pkg.sv
// Shared types, constants and round functions for the SHA-224 engine.
`timescale 1ns / 1ps
package sha224_pkg;

   localparam int unsigned WordBits  = 32;
   localparam int unsigned BlockWords = 16;
   localparam int unsigned RoundCnt  = 64;
   localparam int unsigned DigestWords = 7;
   localparam logic [7:0]  PadByte = 8'h80;

   typedef logic [31:0] word_type;

   // One queued job for the back end: a full 512-bit block and its last flag.
   typedef struct packed {
      logic [511:0] block;
      logic         last;   // final block of a message: emit digest after
   } job_type;

   typedef enum logic [1:0] {
      BE_IDLE,
      BE_ROUND,
      BE_ADD,
      BE_OUT
   } be_state_type;

   typedef enum logic [1:0] {
      FE_TAKE,
      FE_PAD1,
      FE_PAD2
   } fe_state_type;

   localparam word_type InitWords [8] = '{
      32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
      32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
   };

   localparam word_type RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic word_type rotr(input word_type x, input int unsigned n);
      rotr = (x >> n) | (x << (WordBits - n));
   endfunction

   function automatic word_type sig0(input word_type x);
      sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type sig1(input word_type x);
      sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type bsig0(input word_type x);
      bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type bsig1(input word_type x);
      bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

endpackage

// File: design/sha224_front.sv
// Front end: gathers bytes into blocks, counts bits and builds padding blocks.
`timescale 1ns / 1ps
module sha224_front
   import sha224_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [7:0]   in_byte,
   input  logic         in_present,
   input  logic         in_end,
   output logic         job_valid,
   input  logic         job_ready,
   output job_type      job
);

   fe_state_type state_ff, state_in;
   logic [511:0] buf_ff, buf_in;
   logic [5:0]   fill_ff, fill_in;
   logic [63:0]  bits_ff, bits_in;

   logic [511:0] with_byte;
   logic [6:0]   fill_after;
   logic [511:0] pad_blk;
   logic         two_blocks;

   // the byte at index i sits at bits [511-8i -: 8] (big-endian words)
   always_comb begin
      with_byte = buf_ff;
      with_byte[10'(511 - 8 * fill_ff) -: 8] = in_byte;
   end

   assign fill_after = in_present ? 7'(fill_ff) + 7'd1 : 7'(fill_ff);

   // padded tail block built from buffer and count of held bytes
   always_comb begin
      pad_blk = buf_ff;
      for (int i = 0; i < 64; i++) begin
         if (i == fill_ff)
            pad_blk[511 - 8 * i -: 8] = PadByte;
         else if (i > fill_ff)
            pad_blk[511 - 8 * i -: 8] = 8'h00;
      end
   end

   assign two_blocks = (fill_ff >= 6'd56);

   always_comb begin
      state_in = state_ff;
      buf_in   = buf_ff;
      fill_in  = fill_ff;
      bits_in  = bits_ff;
      case (state_ff)
         FE_TAKE: begin
            if (in_valid && in_ready) begin
               if (in_present) begin
                  buf_in  = with_byte;
                  bits_in = bits_ff + 64'd8;
                  fill_in = fill_after[5:0];
               end
               if (in_end)
                  state_in = FE_PAD1;
            end
         end
         FE_PAD1: begin
            if (job_ready) begin
               fill_in = 6'd0;
               if (two_blocks) begin
                  buf_in   = '0;
                  state_in = FE_PAD2;
               end else begin
                  bits_in  = '0;
                  state_in = FE_TAKE;
               end
            end
         end
         FE_PAD2: begin
            if (job_ready) begin
               bits_in  = '0;
               state_in = FE_TAKE;
            end
         end
         default: state_in = FE_TAKE;
      endcase
   end

   // a full block or a pad block is offered to the queue
   always_comb begin
      in_ready  = 1'b0;
      job_valid = 1'b0;
      job.block = pad_blk;
      job.last  = 1'b0;
      case (state_ff)
         FE_TAKE: begin
            // a completing byte needs queue space in the same cycle
            in_ready  = job_ready || !(in_present && fill_ff == 6'd63);
            job_valid = in_valid && in_present && fill_ff == 6'd63;
            job.block = with_byte;
         end
         FE_PAD1: begin
            job_valid = 1'b1;
            job.last  = !two_blocks;
            if (!two_blocks)
               job.block = {pad_blk[511:64], bits_ff};
         end
         FE_PAD2: begin
            job_valid = 1'b1;
            job.last  = 1'b1;
            job.block = {448'd0, bits_ff};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FE_TAKE;
         fill_ff  <= '0;
         bits_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         bits_ff  <= bits_in;
      end
      buf_ff <= buf_in;
   end

`ifndef SYNTHESIS
   a_no_take_padding: assert property (@(posedge clock) disable iff (reset)
      state_ff != FE_TAKE |-> !in_ready)
      else $error("input taken while padding");
   a_count_bytes: assert property (@(posedge clock) disable iff (reset)
      bits_ff[2:0] == 3'd0 && bits_ff[8:3] == fill_ff || state_ff != FE_TAKE)
      else $error("bit count out of step with fill");
   a_pad2_from_pad1: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == FE_PAD2) |-> $past(state_ff == FE_PAD1))
      else $error("bad padding order");
`endif

endmodule

// File: design/sha224_queue.sv
// Two-entry job queue between front end and compression core.
`timescale 1ns / 1ps
module sha224_queue
   import sha224_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_valid,
   output logic    wr_ready,
   input  job_type wr_job,
   output logic    rd_valid,
   input  logic    rd_ready,
   output job_type rd_job
);

   job_type    slot_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] count_ff;
   logic       push, pop;

   assign wr_ready = (count_ff != 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_job   = slot_ff[rptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         if (push) wptr_ff <= ~wptr_ff;
         if (pop)  rptr_ff <= ~rptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
      if (push) slot_ff[wptr_ff] <= wr_job;
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("queue count overflow");
`endif

endmodule

// File: design/sha224_core.sv
// Compression core: one round per cycle, chaining words and digest output.
`timescale 1ns / 1ps
module sha224_core
   import sha224_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         job_valid,
   output logic         job_ready,
   input  job_type      job,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [31:0]  out_word,
   output logic [2:0]   out_index,
   output logic         out_last
);

   be_state_type state_ff, state_in;
   word_type     h_ff [8];
   word_type     v_ff [8];
   word_type     w_ff [16];
   logic [5:0]   round_ff;
   logic [2:0]   idx_ff;
   logic         last_ff;

   word_type t1, t2, wnew, wcur;

   assign wcur = w_ff[0];
   assign t1 = v_ff[7] + bsig1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
             + RoundK[round_ff] + wcur;
   assign t2 = bsig0(v_ff[0]) + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2])
             ^ (v_ff[1] & v_ff[2]));
   // schedule window: w[t+16] = w[t] + s0(w[t+1]) + w[t+9] + s1(w[t+14])
   assign wnew = w_ff[0] + sig0(w_ff[1]) + w_ff[9] + sig1(w_ff[14]);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BE_IDLE:  if (job_valid) state_in = BE_ROUND;
         BE_ROUND: if (round_ff == 6'd63) state_in = BE_ADD;
         BE_ADD:   state_in = last_ff ? BE_OUT : BE_IDLE;
         BE_OUT:   if (out_ready && idx_ff == 3'(DigestWords - 1)) state_in = BE_IDLE;
         default:  state_in = BE_IDLE;
      endcase
   end

   always_comb begin
      job_ready = (state_ff == BE_IDLE);
      out_valid = (state_ff == BE_OUT);
      out_word  = h_ff[idx_ff];
      out_index = idx_ff;
      out_last  = (idx_ff == 3'(DigestWords - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BE_IDLE;
         round_ff <= '0;
         idx_ff   <= '0;
         last_ff  <= 1'b0;
         for (int i = 0; i < 8; i++) h_ff[i] <= InitWords[i];
      end else begin
         state_ff <= state_in;
         case (state_ff)
            BE_IDLE: begin
               round_ff <= '0;
               idx_ff   <= '0;
               if (job_valid) last_ff <= job.last;
            end
            BE_ROUND: round_ff <= round_ff + 6'd1;
            BE_ADD: for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
            BE_OUT: if (out_ready) begin
               idx_ff <= idx_ff + 3'd1;
               if (out_last)
                  for (int i = 0; i < 8; i++) h_ff[i] <= InitWords[i];
            end
            default: ;
         endcase
      end
      if (state_ff == BE_IDLE) begin
         for (int i = 0; i < 16; i++) w_ff[i] <= job.block[511 - 32 * i -: 32];
         for (int i = 0; i < 8; i++)  v_ff[i] <= h_ff[i];
      end else if (state_ff == BE_ROUND) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i + 1];
         w_ff[15] <= wnew;
         for (int i = 1; i < 8; i++) if (i != 4) v_ff[i] <= v_ff[i - 1];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[0] <= t1 + t2;
      end
   end

`ifndef SYNTHESIS
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(idx_ff))
      else $error("digest word dropped");
   a_add_after_rounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == BE_ADD |-> $past(round_ff) == 6'd63)
      else $error("chaining add before last round");
`endif

endmodule

// File: design/sha224_hash_engine.sv
// SHA-224 hash engine top level: byte stream in, digest words out.
`timescale 1ns / 1ps
// Throughput: one byte per cycle into the block buffer, except while padding or
//   while a completing byte waits for queue space; full blocks wait in a
//   two-entry queue; the core takes a block through load, 64 rounds and add.
// Digest: follows the last block's add; seven words, one per cycle if rsp_tready.
// Reset: synchronous active high; restores initial hash words, empties queue.
module sha224_hash_engine
   import sha224_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] data_byte, [8] byte_present, rest zero
   input  logic        req_tlast,   // message_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
   output logic        rsp_tlast    // last_word
);

   logic    fq_valid, fq_ready, qc_valid, qc_ready;
   job_type fq_job, qc_job;
   logic [31:0] word;
   logic [2:0]  index;

   sha224_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_byte(req_tdata[7:0]), .in_present(req_tdata[8]), .in_end(req_tlast),
      .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
   );

   sha224_queue u_queue (
      .clock, .reset,
      .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_job(fq_job),
      .rd_valid(qc_valid), .rd_ready(qc_ready), .rd_job(qc_job)
   );

   sha224_core u_core (
      .clock, .reset,
      .job_valid(qc_valid), .job_ready(qc_ready), .job(qc_job),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_word(word), .out_index(index), .out_last(rsp_tlast)
   );

   assign rsp_tdata = {5'd0, index, word};

endmodule
